### hw/rtl/bod_pkg.sv
// Package for the 4x4 Bayer ordered dither unit: mode codes, register
// indexes, channel limits and the Bayer threshold table.
// No dependencies.
`timescale 1ns / 1ps

package bod_pkg;

  // pixel packing
  localparam int PixelWidth = 24;
  localparam int PhaseWidth = 2;
  localparam int CfgIndexWidth = 8;
  localparam int CfgDataWidth = 8;

  // threshold table entries are 1..16
  localparam int ThreshWidth = 5;

  typedef enum logic {
    FMT_RGB565 = 1'b0,
    FMT_RGB888 = 1'b1
  } pixel_format_t;

  typedef enum logic [1:0] {
    MODE_COLOUR = 2'd0,
    MODE_GREY   = 2'd1,
    MODE_PASS   = 2'd2
  } tone_mode_t;

  // register indexes on the configuration channel
  localparam logic [CfgIndexWidth-1:0] REG_PIXEL_FORMAT = CfgIndexWidth'(0);
  localparam logic [CfgIndexWidth-1:0] REG_TONE_MODE    = CfgIndexWidth'(1);

  // full-scale values of each channel
  localparam logic [4:0]  MAX_RB565 = 5'd31;
  localparam logic [5:0]  MAX_G565  = 6'd63;
  localparam logic [7:0]  MAX_888   = 8'd255;
  localparam logic [15:0] MAX_WORD  = 16'd65535;

  // bayer thresholds, indexed by {row_phase, column_phase}
  localparam logic [ThreshWidth-1:0] BAYER_TAB [16] = '{
    5'd6,  5'd14, 5'd8,  5'd16,
    5'd10, 5'd2,  5'd12, 5'd4,
    5'd7,  5'd15, 5'd5,  5'd13,
    5'd11, 5'd3,  5'd9,  5'd1
  };

  // settings handed to the dither datapath
  typedef struct packed {
    pixel_format_t fmt;
    logic [1:0]    mode;
  } bod_cfg_t;

endpackage

### hw/rtl/bod_datapath.sv
// Combinational dither datapath: Bayer lookup, threshold scaling and
// per-channel compares for RGB565 and RGB888. Depends on bod_pkg.
`timescale 1ns / 1ps

module bod_datapath (
  input  logic [bod_pkg::PixelWidth-1:0] pixel_in,
  input  logic [bod_pkg::PhaseWidth-1:0] column_phase,
  input  logic [bod_pkg::PhaseWidth-1:0] row_phase,
  input  bod_pkg::bod_cfg_t              cfg,
  output logic [bod_pkg::PixelWidth-1:0] pixel_out
);
  import bod_pkg::*;

  logic [ThreshWidth-1:0] t;
  logic [9:0]  prod_rb;
  logic [10:0] prod_g;
  logic [12:0] prod_8;
  logic [20:0] prod_w;
  logic [4:0]  lim_rb;
  logic [5:0]  lim_g;
  logic [7:0]  lim_8;
  logic [15:0] lim_w;

  logic [15:0] w;
  logic [4:0]  r5, b5;
  logic [5:0]  g6;
  logic [7:0]  r8, g8, b8;
  logic [4:0]  r5_q, b5_q;
  logic [5:0]  g6_q;
  logic [7:0]  r8_q, g8_q, b8_q;
  logic [15:0] res565;
  logic [23:0] res888;

  // threshold lookup and scaling by t*max/16
  assign t       = BAYER_TAB[{row_phase, column_phase}];
  assign prod_rb = 10'(t) * 10'(MAX_RB565);
  assign prod_g  = 11'(t) * 11'(MAX_G565);
  assign prod_8  = 13'(t) * 13'(MAX_888);
  assign prod_w  = 21'(t) * 21'(MAX_WORD);
  assign lim_rb  = prod_rb[8:4];
  assign lim_g   = prod_g[9:4];
  assign lim_8   = prod_8[11:4];
  assign lim_w   = prod_w[19:4];

  // channel split
  assign w  = pixel_in[15:0];
  assign r5 = w[15:11];
  assign g6 = w[10:5];
  assign b5 = w[4:0];
  assign r8 = pixel_in[23:16];
  assign g8 = pixel_in[15:8];
  assign b8 = pixel_in[7:0];

  // strict compares against the scaled threshold
  assign r5_q = (r5 > lim_rb) ? MAX_RB565 : '0;
  assign g6_q = (g6 > lim_g)  ? MAX_G565  : '0;
  assign b5_q = (b5 > lim_rb) ? MAX_RB565 : '0;
  assign r8_q = (r8 > lim_8)  ? MAX_888   : '0;
  assign g8_q = (g8 > lim_8)  ? MAX_888   : '0;
  assign b8_q = (b8 > lim_8)  ? MAX_888   : '0;

  // mode select, unused mode code passes through
  always_comb begin
    unique case (cfg.mode)
      MODE_COLOUR: begin
        res565 = {r5_q, g6_q, b5_q};
        res888 = {r8_q, g8_q, b8_q};
      end
      MODE_GREY: begin
        res565 = (w > lim_w) ? MAX_WORD : '0;
        res888 = {r8_q, r8_q, r8_q};
      end
      default: begin
        res565 = w;
        res888 = pixel_in;
      end
    endcase
  end

  assign pixel_out = (cfg.fmt == FMT_RGB888) ? res888 : {8'd0, res565};

endmodule

### hw/rtl/bayer_ordered_dither_4x4_unit.sv
// Top level of the 4x4 Bayer ordered dither unit: input register,
// configuration registers and result register. Depends on bod_pkg, bod_datapath.
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// item in   in         start / busy       pixel_in, column_phase, row_phase
// result    out        done strobe        pixel_out
// config    in         cfg_valid/ready    cfg_index, cfg_data
//
// one item per clock while busy is low; the item is taken into the input register,
// and done rises when its result is loaded into the result register
// busy is set in reset and cleared at a clock edge without reset; never from back-pressure
// done stays high for one cycle per item, the receiver cannot stall
// synchronous active-high reset clears the configuration registers to RGB565 colour mode

module bayer_ordered_dither_4x4_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [bod_pkg::PixelWidth-1:0]      pixel_in,
  input  logic [bod_pkg::PhaseWidth-1:0]      column_phase,
  input  logic [bod_pkg::PhaseWidth-1:0]      row_phase,
  output logic                                done,
  output logic [bod_pkg::PixelWidth-1:0]      pixel_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bod_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [bod_pkg::CfgDataWidth-1:0]    cfg_data
);
  import bod_pkg::*;

  bod_cfg_t                cfg;
  logic                    in_valid;
  logic [PixelWidth-1:0]   in_pixel;
  logic [PhaseWidth-1:0]   in_col;
  logic [PhaseWidth-1:0]   in_row;
  logic [PixelWidth-1:0]   pixel_next;
  logic                    accept;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // startup hold and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      cfg.fmt  <= FMT_RGB565;
      cfg.mode <= MODE_COLOUR;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PIXEL_FORMAT: cfg.fmt  <= pixel_format_t'(cfg_data[0]);
          REG_TONE_MODE:    cfg.mode <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
    if (accept) begin
      in_pixel <= pixel_in;
      in_col   <= column_phase;
      in_row   <= row_phase;
    end
  end

  bod_datapath u_datapath (
    .pixel_in     (in_pixel),
    .column_phase (in_col),
    .row_phase    (in_row),
    .cfg          (cfg),
    .pixel_out    (pixel_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      pixel_out <= pixel_next;
    end
  end

  // every result traces back to an accepted item, through the input and result registers
  a_done_from_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result without an accepted item");

  // an accepted item reaches the input register
  a_item_staged: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_valid)
    else $error("accepted item lost");

  // RGB565 results keep the upper byte clear
  a_565_upper_zero: assert property (@(posedge clk) disable iff (rst)
    (done && pixel_out[23:16] != 8'd0) |-> ($past(cfg.fmt) == FMT_RGB888))
    else $error("upper byte set on an RGB565 result");

  // reset leaves the startup hold on, so no item is taken straight after it
  a_busy_after_reset: assert property (@(posedge clk)
    rst |=> busy)
    else $error("busy low right after reset");

endmodule
